/* hw/rtl/conv3_pkg.sv */
package conv3_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS     = COL_BITS + 1;
  localparam int PIXEL_BITS     = 16;
  localparam int COEF_BITS      = 16;
  localparam int COEF_FRAC_BITS = 8;
  localparam int KROW_BITS      = 3 * COEF_BITS;
  localparam int PROD_BITS      = PIXEL_BITS + COEF_BITS;
  localparam int COLSUM_BITS    = PROD_BITS + 2;
  localparam int SUM_BITS       = PROD_BITS + 4;
  localparam int OUT_BITS       = 27;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = KROW_BITS;
  localparam int RES_DEPTH      = 16;
  localparam int RES_PTR_BITS   = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS   = RES_PTR_BITS + 1;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic [COL_BITS-1:0]          col_t;
  typedef logic [WIDTH_BITS-1:0]        width_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_KERNEL_TOP    = 2'd0,
    CFG_KERNEL_MIDDLE = 2'd1,
    CFG_KERNEL_BOTTOM = 2'd2,
    CFG_LINE_WIDTH    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ROW_FIRST = 3'b001,
    ROW_LATER = 3'b010,
    ROW_DRAIN = 3'b100
  } row_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_LOAD  = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic   mid_we;
    col_t   mid_addr;
    pixel_t mid_data;
    logic   up_we;
    col_t   up_addr;
    pixel_t up_data;
  } ls_wr_t;

  typedef struct packed {
    logic last_of_run;
    logic frame_end;
  } job_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] filtered;
    logic                       last_of_run;
    logic                       frame_end;
  } result_t;

endpackage

/* hw/rtl/conv3_if.sv */
interface conv3_pix_if;
  import conv3_pkg::*;
  logic   valid;
  logic   ready;
  logic   mode;
  pixel_t pixel;
  modport source (output valid, output mode, output pixel, input ready);
  modport sink (input valid, input mode, input pixel, output ready);
endinterface

interface conv3_res_if;
  import conv3_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] filtered;
  logic                       last_of_run;
  logic                       frame_end;
  modport source (output valid, output filtered, output last_of_run, output frame_end,
                  input ready);
  modport sink (input valid, input filtered, input last_of_run, input frame_end,
                output ready);
endinterface

interface conv3_cfg_if;
  import conv3_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/conv3_col_cell.sv */
module conv3_col_cell (
  input  logic                                   clk,
  input  conv3_pkg::cell_op_t                    op,
  input  conv3_pkg::pixel_t                      load_col  [3],
  input  conv3_pkg::pixel_t                      shift_col [3],
  input  conv3_pkg::coef_t                       coef      [3],
  output conv3_pkg::pixel_t                      col       [3],
  output logic signed [conv3_pkg::COLSUM_BITS-1:0] colsum
);
  import conv3_pkg::*;

  logic signed [PROD_BITS-1:0] prod [3];

  // one window column: take a new column or the neighbour's, or keep its own, then weigh it
  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:  col <= load_col;
      CELL_SHIFT: col <= shift_col;
      default:    col <= col;
    endcase
    for (int r = 0; r < 3; r++) begin
      prod[r] <= col[r] * coef[r];
    end
    colsum <= COLSUM_BITS'(prod[0]) + COLSUM_BITS'(prod[1]) + COLSUM_BITS'(prod[2]);
  end

endmodule

/* hw/rtl/conv3_line_store.sv */
module conv3_line_store (
  input  logic              clk,
  input  logic              rst,
  input  conv3_pkg::col_t   rd_addr,
  input  conv3_pkg::ls_wr_t wr,
  output conv3_pkg::pixel_t upper_q,
  output conv3_pkg::pixel_t middle_q
);
  import conv3_pkg::*;

  pixel_t upper_mem  [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];
  pixel_t upper_rd;
  pixel_t fwd_data;
  logic   fwd;

  always_ff @(posedge clk) begin
    if (wr.mid_we) begin
      middle_mem[wr.mid_addr] <= wr.mid_data;
    end
    middle_q <= middle_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.up_we) begin
      upper_mem[wr.up_addr] <= wr.up_data;
    end
    upper_rd <= upper_mem[rd_addr];
  end

  // upper row write trails its read; bypass a read that meets that write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= wr.up_we && (wr.up_addr == rd_addr);
    end
    fwd_data <= wr.up_data;
  end

  assign upper_q = fwd ? fwd_data : upper_rd;

endmodule

/* hw/rtl/conv3_result_fifo.sv */
module conv3_result_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  conv3_pkg::result_t push_data,
  input  logic               pop,
  output conv3_pkg::result_t head,
  output logic               not_empty
);
  import conv3_pkg::*;

  result_t                 mem [RES_DEPTH];
  logic [RES_PTR_BITS-1:0] wr_ptr;
  logic [RES_PTR_BITS-1:0] rd_ptr;
  logic [RES_CNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + RES_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_BITS'(1);
      end
      count <= count + RES_CNT_BITS'(push) - RES_CNT_BITS'(pop);
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

/* hw/rtl/conv3x3_replicate_border_unit.sv */
// Streaming 3x3 convolution (correlation form) over a raster image with
// replicated borders. Pixels arrive on pix_in in raster order, line_width per
// row (0 acts as 1, above 1024 as 1024); mode 1 marks a flush item, and once
// the last row is in, line_width flush items drain it. Results trail the
// input by one row and leave on res_out; filtered is the weighted sum of
// signed 16-bit pixels and signed Q8.8 weights, shifted right by 8 with
// floor, in 27 bits. last_of_run marks the final result of an item and
// frame_end the last result of the image. Rate: one item per clock while
// pix_in is not stalled; an item that closes a row with two results makes
// the input wait while the window cells take their extra replicate step.
// The first row and rows of width one never need that step. A 16-entry
// result queue lets input keep flowing while results wait; input also
// stalls when the queue, counting results still in the pipeline, has no
// room for two more. Write configuration only while no item is in flight.
module conv3x3_replicate_border_unit (
  input  logic        clk,
  input  logic        rst,
  conv3_pix_if.sink   pix_in,
  conv3_res_if.source res_out,
  conv3_cfg_if.sink   cfg
);
  import conv3_pkg::*;

  // configuration registers
  logic [KROW_BITS-1:0] kernel_row [3];
  width_t               line_width;

  // front end: row and column tracking
  row_state_t              row_state;
  row_state_t              rs_post;
  row_state_t              row_state_next;
  col_t                    column_count;
  width_t                  w_eff;
  width_t                  c_ext;
  col_t                    c;
  logic                    last;
  logic                    is_flush;
  logic                    ignore;
  logic                    in_fire;
  logic                    go;
  logic                    emit_any;
  logic                    emit_a;
  logic                    emit_b;
  logic [1:0]              n_res;
  logic [RES_CNT_BITS-1:0] used;
  logic                    pop;

  // stage 1: item with its line store read data
  logic   s1_valid;
  logic   s1_flush;
  logic   s1_first;
  logic   s1_load;
  logic   s1_job;
  logic   s1_dbl;
  job_t   s1_flags;
  logic   s1_dbl_fend;
  col_t   s1_addr;
  pixel_t s1_px;
  pixel_t upper_q;
  pixel_t middle_q;
  ls_wr_t ls_wr;
  pixel_t v_col [3];

  // replicate step after a row closes with two results
  logic rep;
  logic rep_fend;

  // window cells and result pipeline
  cell_op_t                    cell_op    [3];
  pixel_t                      cell_col   [3][3];
  pixel_t                      cell_shift [3][3];
  coef_t                       cell_coef  [3][3];
  logic signed [COLSUM_BITS-1:0] colsum   [3];
  logic [3:0]                  job_v;
  job_t                        job_f [4];
  job_t                        job_new;
  logic signed [SUM_BITS-1:0]  total;
  result_t                     push_data;
  result_t                     head;
  logic                        not_empty;

  // -------------------------------------------------------------------------
  // configuration: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_row[0] <= '0;
      kernel_row[1] <= '0;
      kernel_row[2] <= '0;
      line_width    <= WIDTH_BITS'(MAX_WIDTH);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_KERNEL_TOP:    kernel_row[0] <= cfg.data;
        CFG_KERNEL_MIDDLE: kernel_row[1] <= cfg.data;
        CFG_KERNEL_BOTTOM: kernel_row[2] <= cfg.data;
        CFG_LINE_WIDTH:    line_width    <= cfg.data[WIDTH_BITS-1:0];
        default:           line_width    <= line_width;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // front end: clamp width and column, decide how many results the item owes
  always_comb begin
    if (line_width == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (line_width > WIDTH_BITS'(MAX_WIDTH)) begin
      w_eff = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_eff = line_width;
    end
    // a column at or past the end (width shrunk mid-row) ends the row
    c_ext = {1'b0, column_count};
    if (c_ext >= w_eff) begin
      c_ext = w_eff - WIDTH_BITS'(1);
    end
    c    = c_ext[COL_BITS-1:0];
    last = (c_ext + WIDTH_BITS'(1)) >= w_eff;

    is_flush = pix_in.mode;
    // flush needs a complete row; pixels are dropped while draining
    if (is_flush) begin
      ignore  = (row_state == ROW_FIRST) ||
                ((row_state == ROW_LATER) && (column_count != '0));
      rs_post = ROW_DRAIN;
    end else begin
      ignore  = (row_state == ROW_DRAIN);
      rs_post = row_state;
    end

    emit_any = (rs_post != ROW_FIRST);
    emit_a   = emit_any && (c != '0);
    emit_b   = emit_any && last;
    n_res    = {emit_a && emit_b, emit_a ^ emit_b};

    unique case (rs_post)
      ROW_FIRST: row_state_next = last ? ROW_LATER : ROW_FIRST;
      ROW_LATER: row_state_next = ROW_LATER;
      ROW_DRAIN: row_state_next = last ? ROW_FIRST : ROW_DRAIN;
      default:   row_state_next = ROW_FIRST;
    endcase
  end

  // hold input while the replicate step runs or the queue could overflow
  assign pix_in.ready = (used <= RES_CNT_BITS'(RES_DEPTH - 2)) && !(s1_valid && s1_dbl);
  assign in_fire      = pix_in.valid && pix_in.ready;
  assign go           = in_fire && !ignore;
  assign pop          = res_out.valid && res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_state    <= ROW_FIRST;
      column_count <= '0;
      used         <= '0;
    end else begin
      if (go) begin
        row_state    <= row_state_next;
        column_count <= last ? '0 : c + COL_BITS'(1);
      end
      used <= used + (go ? RES_CNT_BITS'(n_res) : '0) - RES_CNT_BITS'(pop);
    end
  end

  // -------------------------------------------------------------------------
  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      rep      <= 1'b0;
    end else begin
      s1_valid <= go;
      rep      <= s1_valid && s1_dbl;
    end
    s1_flush             <= is_flush;
    s1_first             <= (row_state == ROW_FIRST);
    s1_load              <= (c == '0);
    s1_addr              <= c;
    s1_px                <= pix_in.pixel;
    // with a single column the loaded window already is the right-edge one
    s1_job               <= emit_a || emit_b;
    s1_dbl               <= emit_a && emit_b;
    s1_flags.last_of_run <= emit_a ? !last : 1'b1;
    s1_flags.frame_end   <= emit_a ? 1'b0 : (rs_post == ROW_DRAIN);
    s1_dbl_fend          <= (rs_post == ROW_DRAIN);
    rep_fend             <= s1_dbl_fend;
  end

  // middle row written at accept, upper row in the cycle after, from the read
  always_comb begin
    ls_wr.mid_we   = go && !is_flush;
    ls_wr.mid_addr = c;
    ls_wr.mid_data = pix_in.pixel;
    ls_wr.up_we    = s1_valid && !s1_flush;
    ls_wr.up_addr  = s1_addr;
    ls_wr.up_data  = s1_first ? s1_px : middle_q;
  end

  conv3_line_store u_line_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (c),
    .wr       (ls_wr),
    .upper_q  (upper_q),
    .middle_q (middle_q)
  );

  // new column: first row replicates itself upward, flush replicates downward
  always_comb begin
    v_col[0] = s1_first ? s1_px : upper_q;
    v_col[1] = s1_first ? s1_px : middle_q;
    v_col[2] = s1_flush ? v_col[1] : s1_px;
  end

  // -------------------------------------------------------------------------
  // window cells: each hands its column to the left neighbour
  assign cell_shift[0] = cell_col[1];
  assign cell_shift[1] = cell_col[2];
  assign cell_shift[2] = v_col;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        cell_coef[k][r] = kernel_row[r][k*COEF_BITS +: COEF_BITS];
      end
      if (s1_valid) begin
        cell_op[k] = s1_load ? CELL_LOAD : CELL_SHIFT;
      end else if (rep) begin
        // right edge: keep the last column, slide the others
        cell_op[k] = (k == 2) ? CELL_HOLD : CELL_SHIFT;
      end else begin
        cell_op[k] = CELL_HOLD;
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_cell
    conv3_col_cell u_cell (
      .clk       (clk),
      .op        (cell_op[k]),
      .load_col  (v_col),
      .shift_col (cell_shift[k]),
      .coef      (cell_coef[k]),
      .col       (cell_col[k]),
      .colsum    (colsum[k])
    );
  end

  // -------------------------------------------------------------------------
  // result tags follow window, product, column sum and total stages
  always_comb begin
    if (rep) begin
      job_new.last_of_run = 1'b1;
      job_new.frame_end   = rep_fend;
    end else begin
      job_new = s1_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_v <= '0;
    end else begin
      job_v <= {job_v[2:0], (s1_valid && s1_job) || rep};
    end
    job_f[0] <= job_new;
    job_f[1] <= job_f[0];
    job_f[2] <= job_f[1];
    job_f[3] <= job_f[2];
    total    <= SUM_BITS'(colsum[0]) + SUM_BITS'(colsum[1]) + SUM_BITS'(colsum[2]);
  end

  // floor shift by the coefficient fraction, keep the output width
  always_comb begin
    push_data.filtered    = total[OUT_BITS+COEF_FRAC_BITS-1:COEF_FRAC_BITS];
    push_data.last_of_run = job_f[3].last_of_run;
    push_data.frame_end   = job_f[3].frame_end;
  end

  conv3_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_v[3]),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  assign res_out.valid       = not_empty;
  assign res_out.filtered    = head.filtered;
  assign res_out.last_of_run = head.last_of_run;
  assign res_out.frame_end   = head.frame_end;

  // -------------------------------------------------------------------------
  // reserved results never exceed the queue
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= RES_CNT_BITS'(RES_DEPTH))
    else $error("result reservations exceed queue depth");

  // a two-result item is followed by the replicate step and no new item
  a_rep_bubble: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_dbl) |=> (rep && !s1_valid))
    else $error("replicate step missing or overlapped by an item");

  // a result on the port was reserved
  a_out_reserved: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> (used != '0))
    else $error("result offered without reservation");

  // every pipeline result lands on a reservation
  a_push_reserved: assert property (@(posedge clk) disable iff (rst)
    job_v[3] |-> (used != '0))
    else $error("result pushed without reservation");

endmodule
